FILE: sv/homography_bilinear_warp_top_defines.svh
// Assertion macros shared by the checker of the warp block.
`ifndef HOMOGRAPHY_BILINEAR_WARP_TOP_DEFINES_SVH
`define HOMOGRAPHY_BILINEAR_WARP_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define HBW_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define HBW_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/hbw_pkg.sv
// Types, constants and helpers of the homography warp block.
`timescale 1ns / 1ps

package hbw_pkg;

    localparam int IMG_WIDTH  = 640;
    localparam int IMG_HEIGHT = 480;
    localparam int CHANNELS   = 3;

    localparam int COL_W = 10;
    localparam int ROW_W = 9;
    localparam int CH_W  = 8;
    localparam int PIX_W = 24;

    localparam int COEF_W    = 48;
    localparam int NUM_REGS  = 8;
    localparam int CFG_IDX_W = 3;

    localparam int X_W = $clog2(IMG_WIDTH);
    localparam int Y_W = $clog2(IMG_HEIGHT);

    // coef * coordinate, coordinate taken as signed with one extra bit
    localparam int PROD_W = COEF_W + COL_W + 1;
    localparam int NUM_W  = PROD_W + 2;
    localparam int MAG_W  = NUM_W;
    localparam int REM_W  = MAG_W + 1;

    localparam int FRAC_W  = 16;
    localparam int QI_W    = (X_W > Y_W) ? X_W : Y_W;
    localparam int Q_W     = QI_W + FRAC_W;
    localparam int DIV_LAT = Q_W + 1;

    localparam int HALF_W     = (IMG_WIDTH + 1) / 2;
    localparam int HALF_H     = (IMG_HEIGHT + 1) / 2;
    localparam int BANK_DEPTH = HALF_W * HALF_H;
    localparam int BANK_AW    = $clog2(BANK_DEPTH);
    localparam int NUM_BANKS  = 4;

    localparam int TOP_W = CH_W + FRAC_W + 1;
    localparam int VAL_W = TOP_W + FRAC_W + 1;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    localparam logic signed [COEF_W-1:0] ONE_Q32 = 48'sh0001_0000_0000;

    localparam logic [Q_W-1:0] X_BOUND = Q_W'(IMG_WIDTH - 1) << FRAC_W;
    localparam logic [Q_W-1:0] Y_BOUND = Q_W'(IMG_HEIGHT - 1) << FRAC_W;

    localparam logic [CFG_IDX_W-1:0] REG_H_XU = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_H_XV = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_H_X0 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_H_YU = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_H_YV = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_H_Y0 = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_H_WU = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_H_WV = 3'd7;

    localparam logic FUNC_LOAD   = 1'b0;
    localparam logic FUNC_SAMPLE = 1'b1;

    typedef enum logic {
        KIND_LOAD,
        KIND_SAMPLE
    } item_kind_t;

    typedef struct packed {
        item_kind_t       kind;
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        logic [PIX_W-1:0] pixel;
    } item_t;

    typedef struct packed {
        item_t item;
        logic  bad;
    } side_t;

    // Word address inside a parity bank: half row times half stride plus half column.
    function automatic logic [BANK_AW-1:0] bank_addr(input logic [X_W-1:0] x,
                                                     input logic [Y_W-1:0] y);
        logic [31:0] a;
        a = 32'(y >> 1) * 32'(HALF_W) + 32'(x >> 1);
        return a[BANK_AW-1:0];
    endfunction

endpackage

FILE: sv/hbw_ifs.sv
// Channel interfaces of the homography warp block.
`timescale 1ns / 1ps

interface hbw_item_if import hbw_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             func;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic [PIX_W-1:0] pixel_in;

    modport source (output valid, func, col, row, pixel_in, input ready);
    modport sink   (input valid, func, col, row, pixel_in, output ready);
endinterface

interface hbw_res_if import hbw_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel_out;
    logic             inside_res;

    modport source (output valid, pixel_out, inside_res, input ready);
    modport sink   (input valid, pixel_out, inside_res, output ready);
endinterface

interface hbw_cfg_if import hbw_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] addr;
    logic [COEF_W-1:0]    data;

    modport source (output valid, addr, data, input ready);
    modport sink   (input valid, addr, data, output ready);
endinterface

FILE: sv/homography_bilinear_warp_top.sv
// Top level of the inverse homography warp with bilinear sampling.
`timescale 1ns / 1ps
//
// Usage:
//   items   : item in. func 0 loads pixel_in at (col,row) of the 640x480
//             source image, func 1 samples destination pixel (col,row).
//   results : one item per sample, none per load: pixel_out, inside_res.
//   cfg     : coefficient writes, addr 0..7 = h_xu..h_wv, always ready.
//             Write only while the block is drained.
// Throughput: one item per clock while results are taken, loads and samples mixed freely.
// Latency from acceptance to result comes mostly from the pipelined divider
//   (one quotient bit per stage).
// The source image sits in four parity banks (even/odd row and column),
//   so the four neighbours are read in the same cycle, one read per bank.
// A stalled receiver holds the result register and freezes the back end;
//   the four-item queue and the input register keep taking items
//   until they fill, then items.ready drops.
// Reset: coefficients to identity, pipeline and queue empty. Image
//   content is undefined until loaded; no clearing pass.
//

module homography_bilinear_warp_top import hbw_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    hbw_item_if.sink   items,
    hbw_res_if.source  results,
    hbw_cfg_if.sink    cfg
);

    logic  push;
    item_t push_item;
    logic  fifo_full;
    logic  pop;
    logic  head_valid;
    item_t head_item;

    // front end: input register and load range check
    hbw_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (items.valid),
        .in_ready  (items.ready),
        .in_func   (items.func),
        .in_col    (items.col),
        .in_row    (items.row),
        .in_pixel  (items.pixel_in),
        .push      (push),
        .push_item (push_item),
        .fifo_full (fifo_full)
    );

    // decouples input acceptance from back-end stalls
    hbw_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_item  (push_item),
        .full       (fifo_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_item  (head_item)
    );

    // back end: mapping, divide, image store and blend, result register
    hbw_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg.valid),
        .cfg_ready  (cfg.ready),
        .cfg_addr   (cfg.addr),
        .cfg_data   (cfg.data),
        .fifo_valid (head_valid),
        .fifo_item  (head_item),
        .pop        (pop),
        .out_valid  (results.valid),
        .out_ready  (results.ready),
        .pixel_out  (results.pixel_out),
        .inside_res (results.inside_res)
    );

endmodule

FILE: sv/hbw_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module hbw_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: sv/hbw_front.sv
// Front end: takes items, drops out-of-image loads, tags the rest.
`timescale 1ns / 1ps

module hbw_front import hbw_pkg::*; (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic             in_func,
    input  logic [COL_W-1:0] in_col,
    input  logic [ROW_W-1:0] in_row,
    input  logic [PIX_W-1:0] in_pixel,
    output logic             push,
    output item_t            push_item,
    input  logic             fifo_full
);

    logic  f_valid_reg;
    logic  f_valid_next;
    item_t f_item_reg;
    logic  keep;

    always_comb
    begin
        keep     = (in_func == FUNC_SAMPLE) ||
                   ((in_col < COL_W'(IMG_WIDTH)) && (in_row < ROW_W'(IMG_HEIGHT)));
        push     = f_valid_reg && !fifo_full;
        in_ready = !f_valid_reg || !fifo_full;
        f_valid_next = f_valid_reg && !push;
        if (in_valid && in_ready)
        begin
            f_valid_next = keep;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_valid_reg <= 1'b0;
        end
        else
        begin
            f_valid_reg <= f_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            f_item_reg.kind  <= (in_func == FUNC_SAMPLE) ? KIND_SAMPLE : KIND_LOAD;
            f_item_reg.col   <= in_col;
            f_item_reg.row   <= in_row;
            f_item_reg.pixel <= in_pixel;
        end
    end

    assign push_item = f_item_reg;

endmodule

FILE: sv/hbw_fifo.sv
// Short item queue between front end and back end.
`timescale 1ns / 1ps

module hbw_fifo import hbw_pkg::*; (
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  item_t push_item,
    output logic  full,
    input  logic  pop,
    output logic  head_valid,
    output item_t head_item
);

    item_t              mem_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FIFO_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FIFO_AW:0]   count_reg, count_next;

    always_comb
    begin
        full        = (count_reg == (FIFO_AW + 1)'(FIFO_DEPTH));
        head_valid  = (count_reg != '0);
        head_item   = mem_reg[rd_ptr_reg];
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

FILE: sv/hbw_div.sv
// Pipelined restoring divider: one quotient bit per stage, Q.16 result.
`timescale 1ns / 1ps

module hbw_div import hbw_pkg::*; (
    input  logic             clk,
    input  logic             en,
    input  logic [MAG_W-1:0] m,
    input  logic [MAG_W-1:0] d,
    output logic [Q_W-1:0]   q,
    output logic             ovf
);

    logic [REM_W-1:0] rem_reg [DIV_LAT];
    logic [Q_W-1:0]   low_reg [DIV_LAT];
    logic [Q_W-1:0]   quo_reg [DIV_LAT];
    logic [MAG_W-1:0] den_reg [DIV_LAT];
    logic             ovf_reg [DIV_LAT];

    // quotient cannot fit QI_W integer bits when m >= d * 2^QI_W
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= REM_W'(m >> QI_W);
            low_reg[0] <= {m[QI_W-1:0], FRAC_W'(0)};
            quo_reg[0] <= '0;
            den_reg[0] <= d;
            ovf_reg[0] <= {QI_W'(0), m} >= {d, QI_W'(0)};
        end
    end

    for (genvar k = 1; k < DIV_LAT; k++)
    begin : g_stage
        logic [REM_W-1:0] trial;
        logic [REM_W-1:0] diff;
        logic             ge;

        always_comb
        begin
            trial = {rem_reg[k-1][REM_W-2:0], low_reg[k-1][Q_W-1]};
            diff  = trial - {1'b0, den_reg[k-1]};
            ge    = (trial >= {1'b0, den_reg[k-1]});
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k] <= ge ? diff : trial;
                low_reg[k] <= low_reg[k-1] << 1;
                quo_reg[k] <= {quo_reg[k-1][Q_W-2:0], ge};
                den_reg[k] <= den_reg[k-1];
                ovf_reg[k] <= ovf_reg[k-1];
            end
        end
    end

    assign q   = quo_reg[DIV_LAT-1];
    assign ovf = ovf_reg[DIV_LAT-1];

endmodule

FILE: sv/hbw_back.sv
// Back end: coefficients, mapping, divide, banked image store, bilinear blend.
`timescale 1ns / 1ps

module hbw_back import hbw_pkg::*; (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_addr,
    input  logic [COEF_W-1:0]    cfg_data,
    input  logic                 fifo_valid,
    input  item_t                fifo_item,
    output logic                 pop,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [PIX_W-1:0]     pixel_out,
    output logic                 inside_res
);

    logic signed [COEF_W-1:0] coef_reg [NUM_REGS];
    logic adv;

    logic  s0_valid_reg;
    item_t s0_item_reg;

    logic signed [COL_W:0] u_s;
    logic signed [ROW_W:0] v_s;
    logic signed [PROD_W-1:0] p_xu_next, p_xv_next, p_yu_next, p_yv_next, p_wu_next, p_wv_next;
    logic signed [PROD_W-1:0] p_xu_reg, p_xv_reg, p_yu_reg, p_yv_reg, p_wu_reg, p_wv_reg;
    logic  s1_valid_reg;
    item_t s1_item_reg;

    logic signed [NUM_W-1:0] nx_next, ny_next, w_next;
    logic signed [NUM_W-1:0] nx_reg, ny_reg, w_reg;
    logic  s2_valid_reg;
    item_t s2_item_reg;

    logic [MAG_W-1:0] mx_next, my_next, d_next;
    logic [MAG_W-1:0] mx_reg, my_reg, d_reg;
    logic             bad_next;
    logic             s3_valid_reg;
    side_t            s3_side_reg;

    logic  line_valid_reg [DIV_LAT];
    side_t line_side_reg  [DIV_LAT];

    logic [Q_W-1:0] qx, qy;
    logic           ovfx, ovfy;

    logic [X_W-1:0]    x0, x1;
    logic [Y_W-1:0]    y0, y1;
    logic              inside_next;
    side_t             tail;
    logic [BANK_AW-1:0] waddr;
    logic               bank_we    [NUM_BANKS];
    logic [BANK_AW-1:0] bank_raddr [NUM_BANKS];
    logic [PIX_W-1:0]   bank_rdata [NUM_BANKS];

    logic              s4_valid_reg, s4_sample_reg, s4_inside_reg;
    logic [FRAC_W-1:0] s4_ax_reg, s4_ay_reg;
    logic [1:0]        s4_sel00_reg, s4_sel01_reg, s4_sel10_reg, s4_sel11_reg;

    logic [PIX_W-1:0]  p00, p01, p10, p11;
    logic [FRAC_W:0]   wx0;
    logic [TOP_W-1:0]  top_next [CHANNELS];
    logic [TOP_W-1:0]  bot_next [CHANNELS];
    logic [TOP_W-1:0]  top_reg  [CHANNELS];
    logic [TOP_W-1:0]  bot_reg  [CHANNELS];
    logic              s5_valid_reg, s5_inside_reg;
    logic [FRAC_W-1:0] s5_ay_reg;

    logic [FRAC_W:0]  wy0;
    logic [VAL_W-1:0] val;
    logic [PIX_W-1:0] pix_next;

    logic             out_valid_reg;
    logic [PIX_W-1:0] pixel_reg;
    logic             inside_reg;

    // whole back end moves together; it only stops when the result is held
    assign adv       = !out_valid_reg || out_ready;
    assign pop       = adv && fifo_valid;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_REGS; i++)
            begin
                coef_reg[i] <= (i == int'(REG_H_XU) || i == int'(REG_H_YV)) ? ONE_Q32 : '0;
            end
        end
        else if (cfg_valid)
        begin
            coef_reg[cfg_addr] <= cfg_data;
        end
    end

    // products for the two numerators and the denominator
    always_comb
    begin
        u_s = signed'({1'b0, s0_item_reg.col});
        v_s = signed'({1'b0, s0_item_reg.row});
        p_xu_next = PROD_W'(coef_reg[REG_H_XU]) * PROD_W'(u_s);
        p_xv_next = PROD_W'(coef_reg[REG_H_XV]) * PROD_W'(v_s);
        p_yu_next = PROD_W'(coef_reg[REG_H_YU]) * PROD_W'(u_s);
        p_yv_next = PROD_W'(coef_reg[REG_H_YV]) * PROD_W'(v_s);
        p_wu_next = PROD_W'(coef_reg[REG_H_WU]) * PROD_W'(u_s);
        p_wv_next = PROD_W'(coef_reg[REG_H_WV]) * PROD_W'(v_s);
    end

    always_comb
    begin
        nx_next = NUM_W'(p_xu_reg) + NUM_W'(p_xv_reg) + NUM_W'(coef_reg[REG_H_X0]);
        ny_next = NUM_W'(p_yu_reg) + NUM_W'(p_yv_reg) + NUM_W'(coef_reg[REG_H_Y0]);
        w_next  = NUM_W'(p_wu_reg) + NUM_W'(p_wv_reg) + NUM_W'(ONE_Q32);
    end

    // magnitudes and the early reject: zero divisor or negative quotient
    always_comb
    begin
        mx_next  = nx_reg[NUM_W-1] ? MAG_W'(-nx_reg) : MAG_W'(nx_reg);
        my_next  = ny_reg[NUM_W-1] ? MAG_W'(-ny_reg) : MAG_W'(ny_reg);
        d_next   = w_reg[NUM_W-1]  ? MAG_W'(-w_reg)  : MAG_W'(w_reg);
        bad_next = (w_reg == '0) ||
                   ((mx_next != '0) && (nx_reg[NUM_W-1] != w_reg[NUM_W-1])) ||
                   ((my_next != '0) && (ny_reg[NUM_W-1] != w_reg[NUM_W-1]));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            for (int k = 0; k < DIV_LAT; k++)
            begin
                line_valid_reg[k] <= 1'b0;
            end
            s4_valid_reg  <= 1'b0;
            s5_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s0_valid_reg      <= fifo_valid;
            s1_valid_reg      <= s0_valid_reg;
            s2_valid_reg      <= s1_valid_reg;
            s3_valid_reg      <= s2_valid_reg;
            line_valid_reg[0] <= s3_valid_reg;
            for (int k = 1; k < DIV_LAT; k++)
            begin
                line_valid_reg[k] <= line_valid_reg[k-1];
            end
            s4_valid_reg  <= line_valid_reg[DIV_LAT-1];
            s5_valid_reg  <= s4_valid_reg && s4_sample_reg;
            out_valid_reg <= s5_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s0_item_reg <= fifo_item;
            p_xu_reg <= p_xu_next;
            p_xv_reg <= p_xv_next;
            p_yu_reg <= p_yu_next;
            p_yv_reg <= p_yv_next;
            p_wu_reg <= p_wu_next;
            p_wv_reg <= p_wv_next;
            s1_item_reg <= s0_item_reg;
            nx_reg <= nx_next;
            ny_reg <= ny_next;
            w_reg  <= w_next;
            s2_item_reg <= s1_item_reg;
            mx_reg <= mx_next;
            my_reg <= my_next;
            d_reg  <= d_next;
            s3_side_reg.item <= s2_item_reg;
            s3_side_reg.bad  <= bad_next;
            line_side_reg[0] <= s3_side_reg;
            for (int k = 1; k < DIV_LAT; k++)
            begin
                line_side_reg[k] <= line_side_reg[k-1];
            end
        end
    end

    hbw_div u_div_x (
        .clk (clk),
        .en  (adv),
        .m   (mx_reg),
        .d   (d_reg),
        .q   (qx),
        .ovf (ovfx)
    );

    hbw_div u_div_y (
        .clk (clk),
        .en  (adv),
        .m   (my_reg),
        .d   (d_reg),
        .q   (qy),
        .ovf (ovfy)
    );

    // neighbour addresses; right and bottom neighbours clamp at the border
    always_comb
    begin
        tail = line_side_reg[DIV_LAT-1];
        inside_next = !tail.bad && !ovfx && !ovfy && (qx <= X_BOUND) && (qy <= Y_BOUND);
        x0 = qx[FRAC_W+X_W-1:FRAC_W];
        y0 = qy[FRAC_W+Y_W-1:FRAC_W];
        x1 = (x0 == X_W'(IMG_WIDTH - 1))  ? x0 : x0 + 1'b1;
        y1 = (y0 == Y_W'(IMG_HEIGHT - 1)) ? y0 : y0 + 1'b1;
        waddr = bank_addr(X_W'(tail.item.col), Y_W'(tail.item.row));
    end

    for (genvar b = 0; b < NUM_BANKS; b++)
    begin : g_bank
        localparam logic CP = 1'(b % 2);
        localparam logic RP = 1'(b / 2);
        logic [X_W-1:0] cx;
        logic [Y_W-1:0] ry;

        always_comb
        begin
            cx = (x0[0] == CP) ? x0 : x1;
            ry = (y0[0] == RP) ? y0 : y1;
            bank_raddr[b] = bank_addr(cx, ry);
            bank_we[b] = adv && line_valid_reg[DIV_LAT-1] && (tail.item.kind == KIND_LOAD) &&
                         (tail.item.col[0] == CP) && (tail.item.row[0] == RP);
        end

        hbw_ram #(
            .WIDTH (PIX_W),
            .DEPTH (BANK_DEPTH)
        ) u_ram (
            .clk   (clk),
            .we    (bank_we[b]),
            .waddr (waddr),
            .wdata (tail.item.pixel),
            .re    (adv),
            .raddr (bank_raddr[b]),
            .rdata (bank_rdata[b])
        );
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s4_sample_reg <= (tail.item.kind == KIND_SAMPLE);
            s4_inside_reg <= inside_next;
            s4_ax_reg     <= qx[FRAC_W-1:0];
            s4_ay_reg     <= qy[FRAC_W-1:0];
            s4_sel00_reg  <= {y0[0], x0[0]};
            s4_sel01_reg  <= {y0[0], x1[0]};
            s4_sel10_reg  <= {y1[0], x0[0]};
            s4_sel11_reg  <= {y1[0], x1[0]};
        end
    end

    // horizontal blend of both rows
    always_comb
    begin
        p00 = bank_rdata[s4_sel00_reg];
        p01 = bank_rdata[s4_sel01_reg];
        p10 = bank_rdata[s4_sel10_reg];
        p11 = bank_rdata[s4_sel11_reg];
        wx0 = (FRAC_W + 1)'(1 << FRAC_W) - {1'b0, s4_ax_reg};
        for (int c = 0; c < CHANNELS; c++)
        begin
            top_next[c] = TOP_W'(p00[c*CH_W +: CH_W]) * TOP_W'(wx0) +
                          TOP_W'(p01[c*CH_W +: CH_W]) * TOP_W'(s4_ax_reg);
            bot_next[c] = TOP_W'(p10[c*CH_W +: CH_W]) * TOP_W'(wx0) +
                          TOP_W'(p11[c*CH_W +: CH_W]) * TOP_W'(s4_ax_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int c = 0; c < CHANNELS; c++)
            begin
                top_reg[c] <= top_next[c];
                bot_reg[c] <= bot_next[c];
            end
            s5_ay_reg     <= s4_ay_reg;
            s5_inside_reg <= s4_inside_reg;
        end
    end

    // vertical blend, round half up
    always_comb
    begin
        wy0      = (FRAC_W + 1)'(1 << FRAC_W) - {1'b0, s5_ay_reg};
        pix_next = '0;
        for (int c = 0; c < CHANNELS; c++)
        begin
            val = VAL_W'(top_reg[c]) * VAL_W'(wy0) + VAL_W'(bot_reg[c]) * VAL_W'(s5_ay_reg) +
                  VAL_W'(64'h8000_0000);
            pix_next[c*CH_W +: CH_W] = val[2*FRAC_W +: CH_W];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pixel_reg  <= s5_inside_reg ? pix_next : '0;
            inside_reg <= s5_inside_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign pixel_out  = pixel_reg;
    assign inside_res = inside_reg;

endmodule

FILE: sv/hbw_checker.sv
// Port-level checks of the warp block, bound to the top level.
`timescale 1ns / 1ps
`include "homography_bilinear_warp_top_defines.svh"

module hbw_checker import hbw_pkg::*; (
    input logic             clk,
    input logic             rst_n,
    input logic             out_valid,
    input logic             out_ready,
    input logic [PIX_W-1:0] pixel_out,
    input logic             inside_res,
    input logic             cfg_valid,
    input logic             cfg_ready
);

    `HBW_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped under stall")
    `HBW_ASSERT_NEXT(a_out_stable, out_valid && !out_ready,
                     $stable(pixel_out) && $stable(inside_res), "result changed under stall")
    `HBW_ASSERT_SAME(a_outside_black, out_valid && !inside_res, pixel_out == '0,
                     "outside result not black")
    `HBW_ASSERT_SAME(a_cfg_ready, cfg_valid, cfg_ready, "config write refused")

endmodule

bind homography_bilinear_warp_top hbw_checker u_hbw_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (results.valid),
    .out_ready  (results.ready),
    .pixel_out  (results.pixel_out),
    .inside_res (results.inside_res),
    .cfg_valid  (cfg.valid),
    .cfg_ready  (cfg.ready)
);
